// File: rtl/vdi_pkg.sv
// Package for the vertex deduplication indexer.
// Holds shared constants and the controller/datapath command and status types.
package vdi_pkg;
  localparam int TableDepthDef = 1024;
  localparam int KeyW = 256;
  localparam int SumW = 32;
  localparam int SumN = 6;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat
    logic clear;     // reset the entry count
    logic scan_init; // start the scan at entry zero
    logic scan_step; // advance the scan
    logic rd_sums;   // read the sums of the hit entry
    logic wr_hit;    // write back updated sums
    logic wr_new;    // store a new entry
    logic set_full;  // form the overflow result
    logic out_load;  // present the result
  } vdi_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic clear_req; // captured beat starts a mesh
    logic scan_done; // scanned every valid entry
    logic match;     // key at scan pointer matches
    logic full;      // no free entry
  } vdi_sts_t;
endpackage

// File: rtl/vdi_ctrl.sv
// Controller state machine of the vertex deduplication indexer.
// Depends on vdi_pkg for the command and status structs.
module vdi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_busy,
  input  vdi_pkg::vdi_sts_t sts,
  output logic              in_ready,
  output vdi_pkg::vdi_cmd_t cmd
);
  import vdi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_SCAN = 6'b000100,
    S_READ = 6'b001000,
    S_UPD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   hit_r, hit_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.clear     = sts.clear_req;
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          hit_nxt   = 1'b0;
          state_nxt = S_UPD;
        end else if (sts.match) begin
          hit_nxt     = 1'b1;
          cmd.rd_sums = 1'b1;
          state_nxt   = S_READ;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_READ: state_nxt = S_UPD;
      S_UPD: begin
        if (hit_r) cmd.wr_hit = 1'b1;
        else if (sts.full) cmd.set_full = 1'b1;
        else cmd.wr_new = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // A beat is only captured while idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  // Only one kind of store write per vertex.
  a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_hit && cmd.wr_new)) else $error("double write");
  // Result follows a write or overflow step.
  a_upd_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> state_r == S_OUT) else $error("update not followed by output");
endmodule

// File: rtl/vdi_datapath.sv
// Datapath of the vertex deduplication indexer: key and sum memories,
// scan pointer, saturating adders and the output register. Uses vdi_pkg.
module vdi_datapath #(
  parameter int TABLE_DEPTH = vdi_pkg::TableDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vdi_pkg::vdi_cmd_t   cmd,
  output vdi_pkg::vdi_sts_t   sts,
  input  logic [447:0]        in_tdata,
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [207:0]        out_tdata,
  output logic                out_busy
);
  import vdi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [KeyW-1:0]      key_mem [TABLE_DEPTH];
  logic [SumN*SumW-1:0] sum_mem [TABLE_DEPTH];

  logic [KeyW-1:0]      key_r;
  logic [SumN*SumW-1:0] vec_r;
  logic                 som_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        ptr_r;
  logic [KeyW-1:0]      rd_key_r;
  logic [SumN*SumW-1:0] rd_sum_r;
  logic [AW-1:0]        idx_r;
  logic [SumN*SumW-1:0] res_sum_r;
  logic                 res_new_r, res_full_r;
  logic                 rd_valid_r;
  logic [SumN*SumW-1:0] sat_sum;

  // Capture the beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_tdata[KeyW-1:0];
      vec_r <= in_tdata[KeyW +: SumN*SumW];
      som_r <= in_tuser;
    end
  end

  // Entry count and scan pointer; the key read runs one entry ahead of the compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ptr_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) count_r <= '0;
      else if (cmd.wr_new) count_r <= count_r + CW'(1);
      if (cmd.scan_init) begin
        ptr_r      <= '0;
        rd_valid_r <= 1'b1;
      end else if (cmd.scan_step) begin
        ptr_r <= ptr_r + CW'(1);
      end
    end
  end

  // Key memory: registered read at the scan pointer, write on a new entry.
  always_ff @(posedge clk) begin
    if (cmd.wr_new) key_mem[count_r[AW-1:0]] <= key_r;
    if (cmd.scan_init) rd_key_r <= key_mem[0];
    else if (cmd.scan_step) rd_key_r <= key_mem[AW'(ptr_r + CW'(1))];
  end

  assign sts.clear_req = som_r;
  assign sts.scan_done = (ptr_r >= count_r) || (ptr_r >= CW'(TABLE_DEPTH));
  assign sts.match     = rd_valid_r && (rd_key_r == key_r);
  assign sts.full      = (count_r >= CW'(TABLE_DEPTH));

  // Saturating Q16.16 adds of the stored sums and the incoming vectors.
  always_comb begin
    logic signed [SumW:0] s;
    for (int j = 0; j < SumN; j++) begin
      s = $signed({rd_sum_r[j*SumW+SumW-1], rd_sum_r[j*SumW +: SumW]})
        + $signed({vec_r[j*SumW+SumW-1], vec_r[j*SumW +: SumW]});
      if (s[SumW] != s[SumW-1])
        sat_sum[j*SumW +: SumW] = s[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                          : {1'b0, {(SumW-1){1'b1}}};
      else
        sat_sum[j*SumW +: SumW] = s[SumW-1:0];
    end
  end

  // Sum memory read-modify-write and result formation.
  always_ff @(posedge clk) begin
    if (cmd.rd_sums) begin
      rd_sum_r <= sum_mem[ptr_r[AW-1:0]];
      idx_r    <= ptr_r[AW-1:0];
    end
    if (cmd.wr_hit) begin
      sum_mem[idx_r] <= sat_sum;
      res_sum_r      <= sat_sum;
      res_new_r      <= 1'b0;
      res_full_r     <= 1'b0;
    end else if (cmd.wr_new) begin
      sum_mem[count_r[AW-1:0]] <= vec_r;
      res_sum_r  <= vec_r;
      idx_r      <= count_r[AW-1:0];
      res_new_r  <= 1'b1;
      res_full_r <= 1'b0;
    end else if (cmd.set_full) begin
      res_sum_r  <= '0;
      idx_r      <= '0;
      res_new_r  <= 1'b0;
      res_full_r <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (cmd.out_load) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata[9:0]     <= 10'(idx_r);
      out_tdata[10]      <= res_new_r;
      out_tdata[11]      <= res_full_r;
      out_tdata[203:12]  <= res_sum_r;
      out_tdata[207:204] <= '0;
    end
  end

  assign out_busy = out_tvalid && !out_tready;
endmodule

// File: rtl/vertex_dedup_indexer.sv
// Vertex deduplication indexer: compares each vertex key with the stored entries in turn,
// up to the first match; the controller steps through init, scan, a sum read on a hit,
// update and output states, and a miss on a full table yields a result flagged table_full.
// The next input beat is taken only after the result is loaded into the output register,
// which waits while out_tready holds back a previous result; one vertex is handled at a time.
// Synchronous active-low reset empties the table; memories are not cleared.
module vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = vdi_pkg::TableDepthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // position_xy, position_z_normal_x, normal_yz, tex_uv,
  // tangent_x/y/z, bitangent_x/y/z
  input  logic [447:0] in_tdata,
  // start_of_mesh
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_index, is_new, table_full, sum_tangent_x/y/z, sum_bitangent_x/y/z, zero fill
  output logic [207:0] out_tdata
);
  import vdi_pkg::*;

  vdi_cmd_t cmd;
  vdi_sts_t sts;
  logic     out_busy;

  vdi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_busy(out_busy), .sts(sts), .in_ready(in_tready), .cmd(cmd)
  );

  vdi_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_busy(out_busy)
  );
endmodule
